>>> src/ecg_packet_deframer_core_assert.svh
// assertion macros for the ecg packet deframer
`ifndef ECG_PACKET_DEFRAMER_CORE_ASSERT_SVH
`define ECG_PACKET_DEFRAMER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// checked on every rising edge, masked while reset is asserted
`define ECGDF_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ecgdf assertion failed");
// checked on every rising edge, reset included
`define ECGDF_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("ecgdf assertion failed");
`else
`define ECGDF_ASSERT(name, prop)
`define ECGDF_ASSERT_ALWAYS(name, prop)
`endif

`endif

>>> src/ecgdf_pkg.sv
`timescale 1ns / 1ps

package ecgdf_pkg;

  localparam int unsigned RxByteW      = 8;
  localparam int unsigned PacketIdW    = 7;
  localparam int unsigned LeadW        = 16;
  localparam int unsigned CheckByteW   = 8;
  localparam int unsigned OutDataW     = 3 * LeadW + CheckByteW;

  localparam logic [PacketIdW-1:0] PacketIdReset = 7'h08;

  localparam int unsigned DefaultPayloadBytes = 7;

  // one decoded frame
  typedef struct packed {
    logic [CheckByteW-1:0] check_byte;
    logic [LeadW-1:0]      lead_three;
    logic [LeadW-1:0]      lead_two;
    logic [LeadW-1:0]      lead_one;
  } result_t;

endpackage

>>> src/ecg_packet_deframer_core.sv
`timescale 1ns / 1ps

// ECG packet deframer. One received byte is taken on every beat of the slave
// stream, one beat per clock at full rate; a byte is folded into the framing
// state in the same cycle it is accepted. A frame is the packet id byte (bit 7
// clear, equal to the programmed id), a header byte holding the top bits,
// PAYLOAD_BYTES payload bytes and a check byte. The check byte produces one
// master beat carrying three 16 bit samples and the raw, unverified check
// byte. Any byte with bit 7 clear aborts the frame and is judged as a new id
// at once. After the check byte all bytes are dropped until the next byte with
// bit 7 clear. A two entry output queue (output register plus skid register)
// lets the input keep running while a result waits; the input only stalls when
// both entries are full. packet_id is to be written with cfg_we_i while the
// block is idle; the block itself does not enforce this.

`include "ecg_packet_deframer_core_assert.svh"

module ecg_packet_deframer_core
  import ecgdf_pkg::*;
#(
  parameter int unsigned PAYLOAD_BYTES = DefaultPayloadBytes
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  // configuration
  input  logic                 cfg_we_i,
  input  logic [PacketIdW-1:0] cfg_wdata_i,   // packet_id

  // received bytes
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [RxByteW-1:0]   s_axis_tdata,  // [7:0] rx_byte

  // decoded frames
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [15:0] lead_one, [31:16] lead_two, [47:32] lead_three, [55:48] check_byte
  output logic [OutDataW-1:0]  m_axis_tdata
);

  localparam int unsigned CntW = $clog2(PAYLOAD_BYTES);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEAD,
    PH_DATA,
    PH_CHECK,
    PH_DONE
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [RxByteW-1:0]   top_q, top_d;
  logic [PacketIdW-1:0] packet_id_q;
  logic [7:0]           payload_q [PAYLOAD_BYTES];

  result_t out_q, skid_q, res;
  logic    out_valid_q, skid_valid_q;

  logic   in_fire, out_fire, pay_we, res_new;
  phase_e phase_eff;
  logic [RxByteW-1:0] b;

  assign b        = s_axis_tdata;
  assign in_fire  = s_axis_tvalid & s_axis_tready;
  assign out_fire = m_axis_tvalid & m_axis_tready;

  // input stalls only when both queue entries hold a result
  assign s_axis_tready = ~skid_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // a byte with bit 7 clear always restarts framing
  assign phase_eff = b[7] ? phase_q : PH_IDLE;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    top_d   = top_q;
    pay_we  = 1'b0;
    res_new = 1'b0;
    case (phase_eff)
      PH_IDLE: begin
        phase_d = PH_IDLE;
        if (b == {1'b0, packet_id_q}) begin
          phase_d = PH_HEAD;
          cnt_d   = '0;
        end
      end
      PH_HEAD: begin
        top_d   = b;
        phase_d = PH_DATA;
      end
      PH_DATA: begin
        pay_we = 1'b1;
        if (cnt_q == CntW'(PAYLOAD_BYTES - 1)) begin
          phase_d = PH_CHECK;
        end
        cnt_d = cnt_q + 1'b1;
      end
      PH_CHECK: begin
        res_new = 1'b1;
        phase_d = PH_DONE;
      end
      default: begin
        phase_d = phase_q;
      end
    endcase
  end

  assign res.lead_one   = {payload_q[0], payload_q[1]};
  assign res.lead_two   = {payload_q[2], payload_q[3]};
  assign res.lead_three = {payload_q[4], payload_q[5]};
  assign res.check_byte = b;

  // framing state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      cnt_q       <= '0;
      top_q       <= '0;
      packet_id_q <= PacketIdReset;
    end else begin
      if (cfg_we_i) begin
        packet_id_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        top_q   <= top_d;
      end
    end
  end

  // payload bytes get bit 7 back from the header bit at their position
  always_ff @(posedge clk_i) begin
    if (in_fire && pay_we) begin
      payload_q[cnt_q] <= {top_q[cnt_q], b[6:0]};
    end
  end

  // two entry result queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire && res_new) begin
      if (!out_valid_q || out_fire) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire && res_new) begin
      if (!out_valid_q || out_fire) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  `ECGDF_ASSERT(skid_implies_out_a, skid_valid_q |-> out_valid_q)
  `ECGDF_ASSERT(cnt_in_range_a, (phase_q == PH_DATA) |-> cnt_q <= CntW'(PAYLOAD_BYTES - 1))
  `ECGDF_ASSERT(result_from_check_a,
                $rose(out_valid_q) |-> $past(in_fire) && $past(phase_eff == PH_CHECK))
  `ECGDF_ASSERT_ALWAYS(reset_clears_queue_a, !rst_ni |=> !skid_valid_q || !$past(!rst_ni))

endmodule

>>> dv/ecg_packet_deframer_core_test.sv
`timescale 1ns / 1ps

module ecg_packet_deframer_core_test;
  import ecgdf_pkg::*;

  localparam int unsigned NPay       = DefaultPayloadBytes;
  localparam int unsigned FrameLen   = NPay + 3;
  localparam int unsigned StallLimit = 4000;

  typedef enum logic [2:0] {
    FR_IDLE, FR_HEADER, FR_PAYLOAD, FR_CHECK, FR_DONE
  } frame_phase_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [PacketIdW-1:0] cfg_wdata = '0;
  logic                 s_valid = 1'b0;
  logic                 s_axis_tready;
  logic [RxByteW-1:0]   s_data = '0;
  logic                 m_axis_tvalid;
  logic                 m_ready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;
  result_t              got;

  ecg_packet_deframer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata)
  );

  assign got = m_axis_tdata;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // deframer mirror
  logic [PacketIdW-1:0] cur_id = PacketIdReset;
  frame_phase_e         fr_phase = FR_IDLE;
  logic [2:0]           pay_cnt = '0;
  logic [7:0]           hdr_bits = '0;
  logic [7:0]           pay_bytes [NPay];

  result_t pending_frames [$];
  int      errors = 0;
  int      send_pct = 0, recv_pct = 0;
  int      send_eff = 0, recv_eff = 0;
  int      quiet_cycles = 0;

  // directed stimulus rows
  logic [7:0] dir_byte [$];
  bit         dir_typed [$];
  result_t    dir_want [$];

  function automatic bit decode_byte(input logic [7:0] b, output result_t r);
    int k;
    bit hit;
    hit = 1'b0;
    r = '0;
    if (!b[7]) fr_phase = FR_IDLE;
    case (fr_phase)
      FR_IDLE: begin
        if (b == {1'b0, cur_id}) begin
          fr_phase = FR_HEADER;
          pay_cnt = '0;
        end
      end
      FR_HEADER: begin
        hdr_bits = b;
        fr_phase = FR_PAYLOAD;
      end
      FR_PAYLOAD: begin
        k = pay_cnt;
        pay_bytes[k] = {hdr_bits[k], b[6:0]};
        if (k + 1 >= NPay) fr_phase = FR_CHECK;
        pay_cnt = 3'(k + 1);
      end
      FR_CHECK: begin
        r.lead_one   = {pay_bytes[0], pay_bytes[1]};
        r.lead_two   = {pay_bytes[2], pay_bytes[3]};
        r.lead_three = {pay_bytes[4], pay_bytes[5]};
        r.check_byte = b;
        fr_phase = FR_DONE;
        hit = 1'b1;
      end
      default: ;
    endcase
    return hit;
  endfunction

  function automatic void add_row(input logic [7:0] b, input bit typed, input result_t want);
    dir_byte.push_back(b);
    dir_typed.push_back(typed);
    dir_want.push_back(want);
  endfunction

  // one beat on the slave side; a typed row overrides the mirror's result
  task automatic push_byte(input logic [7:0] b, input bit typed, input result_t want);
    result_t r;
    bit hit;
    while ($urandom_range(99) < send_eff) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    hit = decode_byte(b, r);
    if (typed) pending_frames.push_back(want);
    else if (hit) pending_frames.push_back(r);
  endtask

  // hold the sender until all frames are out, let the queue settle, write the id
  task automatic drain_and_write(input logic [PacketIdW-1:0] id);
    s_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= id;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    cur_id = id;
  endtask

  // mostly whole frames with random content, some cut short, some noise
  task automatic send_frame(inout int items);
    int cut;
    int n;
    logic [7:0] b;
    send_eff = ($urandom_range(4) == 0) ? 0 : send_pct;
    recv_eff = ($urandom_range(4) == 0) ? 0 : recv_pct;
    if ($urandom_range(7) == 0) begin
      push_byte(8'($urandom), 1'b0, '0);
      items++;
    end
    cut = ($urandom_range(5) == 0) ? $urandom_range(FrameLen - 1) : FrameLen;
    for (n = 0; n < FrameLen; n++) begin
      if (n == cut) begin
        // abort with a bit 7 clear byte, sometimes the id itself
        b = $urandom_range(1) ? {1'b0, cur_id} : {1'b0, 7'($urandom)};
        push_byte(b, 1'b0, '0);
        items++;
        break;
      end
      if (n == 0) b = {1'b0, cur_id};
      else b = {1'b1, 7'($urandom)};
      push_byte(b, 1'b0, '0);
      items++;
    end
    if (cut == FrameLen) begin
      repeat ($urandom_range(2)) begin
        push_byte({1'b1, 7'($urandom)}, 1'b0, '0);
        items++;
      end
    end
  endtask

  // result side: check each beat, then pick the next ready level
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_ready) begin
      if (pending_frames.size() == 0) begin
        $display("%0t: unexpected frame: exp none act %h", $time, m_axis_tdata);
        errors++;
      end else begin
        if (pending_frames[0].lead_one != got.lead_one) begin
          $display("%0t: lead_one exp %h act %h", $time, pending_frames[0].lead_one,
                   got.lead_one);
          errors++;
        end
        if (pending_frames[0].lead_two != got.lead_two) begin
          $display("%0t: lead_two exp %h act %h", $time, pending_frames[0].lead_two,
                   got.lead_two);
          errors++;
        end
        if (pending_frames[0].lead_three != got.lead_three) begin
          $display("%0t: lead_three exp %h act %h", $time, pending_frames[0].lead_three,
                   got.lead_three);
          errors++;
        end
        if (pending_frames[0].check_byte != got.check_byte) begin
          $display("%0t: check_byte exp %h act %h", $time, pending_frames[0].check_byte,
                   got.check_byte);
          errors++;
        end
        void'(pending_frames.pop_front());
      end
    end
    m_ready <= ($urandom_range(99) >= recv_eff);
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int items;
    int ph;
    int i;
    result_t w;
    foreach (pay_bytes[j]) pay_bytes[j] = '0;

    // idle noise, frame with all header bits clear (top bits dropped)
    add_row(8'h00, 1'b0, '0);
    add_row(8'h08, 1'b0, '0);
    add_row(8'h80, 1'b0, '0);
    for (i = 0; i < NPay; i++) add_row(8'hFF, 1'b0, '0);
    w.lead_one = 16'h7F7F; w.lead_two = 16'h7F7F; w.lead_three = 16'h7F7F;
    w.check_byte = 8'hAA;
    add_row(8'hAA, 1'b1, w);
    // dropped after the check byte, then restart on the id
    add_row(8'h85, 1'b0, '0);
    add_row(8'h08, 1'b0, '0);
    add_row(8'hFF, 1'b0, '0);
    for (i = 0; i < NPay; i++) add_row(8'h80, 1'b0, '0);
    w.lead_one = 16'h8080; w.lead_two = 16'h8080; w.lead_three = 16'h8080;
    w.check_byte = 8'hFF;
    add_row(8'hFF, 1'b1, w);
    // abort at the first payload byte by a new id
    add_row(8'h08, 1'b0, '0);
    add_row(8'hC0, 1'b0, '0);
    add_row(8'h08, 1'b0, '0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_byte[j]) push_byte(dir_byte[j], dir_typed[j], dir_want[j]);

    // random phases, each with its own packet id and idling mix
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_pct = 0;  recv_pct = 0;  end
        1: begin send_pct = 58; recv_pct = 0;  end
        2: begin send_pct = 0;  recv_pct = 58; end
        default: begin send_pct = 8; recv_pct = 8; end
      endcase
      send_eff = 0;
      recv_eff = 0;
      case (ph)
        0: drain_and_write(7'h7F);
        1: drain_and_write(7'h00);
        default: drain_and_write(7'($urandom));
      endcase
      items = 0;
      while (items < 125) send_frame(items);
    end

    s_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
